// ===== rtl/lfps_pkg.sv =====
package lfps_pkg;

  localparam int PROBE_COUNT        = 8;
  localparam int TURN_CONFIRM_LIMIT = 2;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int ACC_W       = 36;

  localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INTEG_GAIN      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_INTEG_GAIN_LEFT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DERIV_GAIN      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CRUISE_SPEED    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_TURN_SPEED      = 3'd5;

  localparam logic [1:0] CMD_STRAIGHT = 2'd0;
  localparam logic [1:0] CMD_LEFT     = 2'd1;
  localparam logic [1:0] CMD_RIGHT    = 2'd2;

  localparam logic [7:0] ALL_WHITE = 8'hFF;

  localparam logic [PROBE_COUNT-1:0] WIN_STRAIGHT = 8'b1111_1111;
  localparam logic [PROBE_COUNT-1:0] WIN_LEFT     = 8'b0011_1111;
  localparam logic [PROBE_COUNT-1:0] WIN_RIGHT    = 8'b1111_0000;

  localparam logic signed [15:0] INTEG_MAX = 16'sd32767;
  localparam logic signed [15:0] INTEG_MIN = -16'sd32767;

  typedef enum logic [1:0] {
    ST_UPDATED   = 2'd0,
    ST_NO_LINE   = 2'd1,
    ST_TURN_DONE = 2'd2,
    ST_SPLIT     = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] sensor_bits;
    logic [1:0] cmd;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] left_drive;
    logic signed [15:0] right_drive;
  } out_item_t;

  typedef struct packed {
    logic [15:0] prop_gain;
    logic [15:0] integ_gain;
    logic [15:0] integ_gain_left;
    logic [15:0] deriv_gain;
    logic [14:0] cruise_speed;
    logic [14:0] turn_speed;
  } cfg_t;

  typedef struct packed {
    logic signed [4:0]  last_error;
    logic signed [15:0] error_integral;
    logic [1:0]         centered_count;
    logic signed [15:0] held_left_drive;
    logic signed [15:0] held_right_drive;
  } state_t;

  function automatic logic signed [4:0] probe_weight(input logic [2:0] idx);
    logic signed [4:0] w;
    case (idx)
      3'd0:    w = -5'sd4;
      3'd1:    w = -5'sd3;
      3'd2:    w = -5'sd2;
      3'd3:    w = -5'sd1;
      3'd4:    w = 5'sd1;
      3'd5:    w = 5'sd2;
      3'd6:    w = 5'sd3;
      default: w = 5'sd4;
    endcase
    return w;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
    logic signed [15:0] r;
    if (v > ACC_W'(32767)) begin
      r = 16'sh7FFF;
    end else if (v < -ACC_W'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/line_follow_pid_steer.sv =====
// Line follower PID steering block.
// Sensor channel: sensor_valid / sensor_stall carry one sensor byte and a
// steering mode per transfer. Result channel: drive_valid / drive_stall carry
// a status code and the left and right drive targets per transfer.
// Every sensor transfer yields exactly one result transfer, in order.
// A sensor item is held in the input register; its result is then loaded
// into the result register on drive, from which it can be taken.
// Throughput: one item per cycle while drive is not stalled; the PID step,
// integral update and turn count for an item are resolved combinationally
// between the input and result registers, so the next item already sees the
// updated loop state.
// Stall: while drive_stall is high the result register holds; the input
// register still takes one more item, then sensor_stall rises until the
// result is taken.
// Reset (rst, synchronous): both registers empty, loop state and held drives
// cleared, gains and speeds back to their defaults. Configuration writes on
// cfg_write / cfg_index / cfg_data take effect at the next clock edge. The
// user must make them only while no item is in flight (not enforced).
module line_follow_pid_steer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [lfps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lfps_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              sensor_valid,
  output logic                              sensor_stall,
  input  lfps_pkg::in_item_t                sensor,
  output logic                              drive_valid,
  input  logic                              drive_stall,
  output lfps_pkg::out_item_t               drive
);

  lfps_pkg::cfg_t      cfg;
  lfps_pkg::state_t    state;
  lfps_pkg::state_t    state_next;
  lfps_pkg::in_item_t  item;
  lfps_pkg::out_item_t result;
  logic                item_valid;
  logic                advance;
  logic                take;

  lfps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lfps_datapath u_dp (
    .item       (item),
    .cfg        (cfg),
    .state      (state),
    .result     (result),
    .state_next (state_next)
  );

  assign advance      = item_valid && (!drive_valid || !drive_stall);
  assign sensor_stall = item_valid && !advance;
  assign take         = sensor_valid && !sensor_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item <= sensor;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_valid <= 1'b0;
    end else if (advance) begin
      drive_valid <= 1'b1;
    end else if (!drive_stall) begin
      drive_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drive <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/lfps_cfg_regs.sv =====
module lfps_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [lfps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lfps_pkg::CFG_DATA_W-1:0]  cfg_data,
  output lfps_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain       <= 16'd3200;
      cfg.integ_gain      <= 16'd13;
      cfg.integ_gain_left <= 16'd128;
      cfg.deriv_gain      <= 16'd2176;
      cfg.cruise_speed    <= 15'd320;
      cfg.turn_speed      <= 15'd320;
    end else if (cfg_write) begin
      case (cfg_index)
        lfps_pkg::REG_PROP_GAIN:       cfg.prop_gain       <= cfg_data;
        lfps_pkg::REG_INTEG_GAIN:      cfg.integ_gain      <= cfg_data;
        lfps_pkg::REG_INTEG_GAIN_LEFT: cfg.integ_gain_left <= cfg_data;
        lfps_pkg::REG_DERIV_GAIN:      cfg.deriv_gain      <= cfg_data;
        lfps_pkg::REG_CRUISE_SPEED:    cfg.cruise_speed    <= cfg_data[14:0];
        lfps_pkg::REG_TURN_SPEED:      cfg.turn_speed      <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/lfps_datapath.sv =====
module lfps_datapath (
  input  lfps_pkg::in_item_t  item,
  input  lfps_pkg::cfg_t      cfg,
  input  lfps_pkg::state_t    state,
  output lfps_pkg::out_item_t result,
  output lfps_pkg::state_t    state_next
);

  localparam int AW = lfps_pkg::ACC_W;

  logic [lfps_pkg::PROBE_COUNT-1:0] window;
  logic                             seen;
  logic                             gap;
  logic                             split;
  logic signed [4:0]                err;
  logic                             turn;

  logic signed [4:0]  prev;
  logic signed [16:0] integ_sum;
  logic signed [15:0] integ;
  logic signed [5:0]  diff;
  logic [15:0]        ki;
  logic signed [16:0] kp_s;
  logic signed [16:0] ki_s;
  logic signed [16:0] kd_s;
  logic signed [21:0] p_prod;
  logic signed [32:0] i_prod;
  logic signed [22:0] d_prod;
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] pid;
  logic signed [AW-1:0] base;
  logic signed [15:0]   left_new;
  logic signed [15:0]   right_new;

  always_comb begin
    case (item.cmd)
      lfps_pkg::CMD_LEFT:  window = lfps_pkg::WIN_LEFT;
      lfps_pkg::CMD_RIGHT: window = lfps_pkg::WIN_RIGHT;
      default:             window = lfps_pkg::WIN_STRAIGHT;
    endcase
  end

  always_comb begin
    seen  = 1'b0;
    gap   = 1'b0;
    split = 1'b0;
    err   = 5'sd0;
    for (int i = 0; i < lfps_pkg::PROBE_COUNT; i++) begin
      if (window[i] && !split) begin
        if (!item.sensor_bits[i]) begin
          if (gap) begin
            split = 1'b1;
          end else begin
            err  = err + lfps_pkg::probe_weight(3'(i));
            seen = 1'b1;
          end
        end else if (seen) begin
          gap = 1'b1;
        end
      end
    end
  end

  assign turn = (item.cmd == lfps_pkg::CMD_LEFT) || (item.cmd == lfps_pkg::CMD_RIGHT);
  assign prev = state.last_error;

  always_comb begin
    integ_sum = {state.error_integral[15], state.error_integral} + 17'(prev);
    if (prev > 5'sd2 || prev < -5'sd2) begin
      if (integ_sum > 17'(lfps_pkg::INTEG_MAX)) begin
        integ = lfps_pkg::INTEG_MAX;
      end else if (integ_sum < 17'(lfps_pkg::INTEG_MIN)) begin
        integ = lfps_pkg::INTEG_MIN;
      end else begin
        integ = integ_sum[15:0];
      end
    end else begin
      integ = 16'sd0;
    end
  end

  assign ki   = (item.cmd == lfps_pkg::CMD_LEFT) ? cfg.integ_gain_left : cfg.integ_gain;
  assign kp_s = $signed({1'b0, cfg.prop_gain});
  assign ki_s = $signed({1'b0, ki});
  assign kd_s = $signed({1'b0, cfg.deriv_gain});
  assign diff = 6'(prev) - 6'(err);

  assign p_prod = 22'(kp_s) * 22'(err);
  assign i_prod = 33'(ki_s) * 33'(integ);
  assign d_prod = 23'(kd_s) * 23'(diff);

  assign acc  = AW'(p_prod) + AW'(i_prod) - AW'(d_prod);
  assign pid  = (acc + AW'(16)) >>> 5;
  assign base = turn ? $signed(AW'({1'b0, cfg.turn_speed}))
                     : $signed(AW'({1'b0, cfg.cruise_speed}));

  assign left_new  = lfps_pkg::sat16(base - pid);
  assign right_new = lfps_pkg::sat16(base + pid);

  always_comb begin
    state_next         = state;
    result.status      = lfps_pkg::ST_UPDATED;
    result.left_drive  = state.held_left_drive;
    result.right_drive = state.held_right_drive;
    if (item.sensor_bits == lfps_pkg::ALL_WHITE) begin
      result.status = lfps_pkg::ST_NO_LINE;
    end else if (split) begin
      result.status = lfps_pkg::ST_SPLIT;
    end else begin
      state_next.error_integral   = integ;
      state_next.last_error       = err;
      state_next.held_left_drive  = left_new;
      state_next.held_right_drive = right_new;
      result.left_drive           = left_new;
      result.right_drive          = right_new;
      if (turn && err == 5'sd0) begin
        if (state.centered_count >= 2'(lfps_pkg::TURN_CONFIRM_LIMIT)) begin
          state_next.centered_count = 2'd0;
          result.status             = lfps_pkg::ST_TURN_DONE;
        end else begin
          state_next.centered_count = state.centered_count + 2'd1;
        end
      end
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int HOLD_CYCLES = 40;
  localparam int DRAIN_LIMIT = 5000;
  localparam logic [lfps_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [lfps_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  class drive_scoreboard;
    logic [15:0]                   kp, ki_main, ki_left, kd;
    logic [14:0]                   cruise, turn;
    logic signed [4:0]             last_err;
    logic signed [15:0]            integ, held_l, held_r;
    logic [1:0]                    centered;
    lfps_pkg::out_item_t           expected_drives[$];
    int                            errors;

    function new();
      kp = 16'd3200;
      ki_main = 16'd13;
      ki_left = 16'd128;
      kd = 16'd2176;
      cruise = 15'd320;
      turn = 15'd320;
      last_err = '0;
      integ = '0;
      held_l = '0;
      held_r = '0;
      centered = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [lfps_pkg::CFG_INDEX_W-1:0] idx,
                          logic [lfps_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        lfps_pkg::REG_PROP_GAIN:       kp = data;
        lfps_pkg::REG_INTEG_GAIN:      ki_main = data;
        lfps_pkg::REG_INTEG_GAIN_LEFT: ki_left = data;
        lfps_pkg::REG_DERIV_GAIN:      kd = data;
        lfps_pkg::REG_CRUISE_SPEED:    cruise = data[14:0];
        lfps_pkg::REG_TURN_SPEED:      turn = data[14:0];
        default: ;
      endcase
    endfunction

    function logic signed [15:0] clamp16(longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
    endfunction

    function lfps_pkg::out_item_t steer_step(lfps_pkg::in_item_t x);
      int                  lo, hi, err, prev, i;
      bit                  seen, gap, split;
      longint              s, acc, pid, base, ki;
      lfps_pkg::out_item_t r;
      lo = 0;
      hi = lfps_pkg::PROBE_COUNT;
      err = 0;
      seen = 1'b0;
      gap = 1'b0;
      split = 1'b0;
      r.status = lfps_pkg::ST_UPDATED;
      if (x.cmd == lfps_pkg::CMD_LEFT) begin
        hi = 6;
      end else if (x.cmd == lfps_pkg::CMD_RIGHT) begin
        lo = 4;
      end
      if (x.sensor_bits == lfps_pkg::ALL_WHITE) begin
        r.status = lfps_pkg::ST_NO_LINE;
      end else begin
        for (i = lo; i < hi; i++) begin
          if (!x.sensor_bits[i]) begin
            if (gap) begin
              split = 1'b1;
              break;
            end
            err += (i <= 3) ? i - 4 : i - 3;
            seen = 1'b1;
          end else if (seen) begin
            gap = 1'b1;
          end
        end
        if (split) begin
          r.status = lfps_pkg::ST_SPLIT;
        end else begin
          prev = last_err;
          if (prev > 2 || prev < -2) begin
            s = longint'(integ) + prev;
            if (s > 32767) s = 32767;
            else if (s < -32767) s = -32767;
          end else begin
            s = 0;
          end
          integ = 16'(s);
          last_err = 5'(err);
          ki = (x.cmd == lfps_pkg::CMD_LEFT) ? longint'(ki_left) : longint'(ki_main);
          acc = longint'(kp) * err + ki * s - longint'(kd) * (prev - err);
          pid = (acc + 16) >>> 5;
          base = (x.cmd == lfps_pkg::CMD_LEFT || x.cmd == lfps_pkg::CMD_RIGHT)
                 ? longint'(turn) : longint'(cruise);
          held_l = clamp16(base - pid);
          held_r = clamp16(base + pid);
          if ((x.cmd == lfps_pkg::CMD_LEFT || x.cmd == lfps_pkg::CMD_RIGHT) && err == 0) begin
            if (centered >= lfps_pkg::TURN_CONFIRM_LIMIT) begin
              centered = '0;
              r.status = lfps_pkg::ST_TURN_DONE;
            end else begin
              centered++;
            end
          end
        end
      end
      r.left_drive = held_l;
      r.right_drive = held_r;
      return r;
    endfunction

    function void note_input(lfps_pkg::in_item_t x);
      expected_drives.push_back(steer_step(x));
    endfunction

    function int pending();
      return expected_drives.size();
    endfunction

    task report(string msg);
      $display("%0t ns: MISMATCH %s", $time, msg);
      errors++;
    endtask

    task check_result(lfps_pkg::out_item_t got);
      lfps_pkg::out_item_t want;
      if (expected_drives.size() == 0) begin
        report($sformatf("unexpected drive transfer status=%0d left=%0d right=%0d",
                         got.status, got.left_drive, got.right_drive));
        return;
      end
      want = expected_drives.pop_front();
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.left_drive !== want.left_drive)
        report($sformatf("left_drive got %0d want %0d", got.left_drive, want.left_drive));
      if (got.right_drive !== want.right_drive)
        report($sformatf("right_drive got %0d want %0d", got.right_drive, want.right_drive));
    endtask
  endclass

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_write = 1'b0;
  logic [lfps_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [lfps_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                             sensor_valid = 1'b0;
  logic                             sensor_stall;
  lfps_pkg::in_item_t               sensor = '0;
  logic                             drive_valid;
  logic                             drive_stall = 1'b0;
  lfps_pkg::out_item_t              drive;

  bit idle_on = 1'b1;
  bit hold_req = 1'b0;

  drive_scoreboard sb = new();

  line_follow_pid_steer uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sensor_valid (sensor_valid),
    .sensor_stall (sensor_stall),
    .sensor       (sensor),
    .drive_valid  (drive_valid),
    .drive_stall  (drive_stall),
    .drive        (drive)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("testbench failed");
    $finish;
  end

  function automatic int draw_gap();
    return idle_on ? int'($urandom_range(0, 10)) : 0;
  endfunction

  function automatic logic [7:0] dark_run();
    int start, len;
    logic [7:0] m;
    start = $urandom_range(0, 7);
    len = $urandom_range(1, 8 - start);
    m = 8'((1 << len) - 1) << start;
    return ~m;
  endfunction

  function automatic logic [7:0] centered_bits(logic [1:0] cmd);
    logic [7:0] b;
    case (cmd)
      lfps_pkg::CMD_LEFT: begin
        case ($urandom_range(0, 4))
          0:       b = 8'h3F;
          1:       b = 8'h7F;
          2:       b = 8'hBF;
          3:       b = 8'hC3;
          default: b = 8'hE7;
        endcase
      end
      lfps_pkg::CMD_RIGHT: begin
        b = 8'hF0 | 8'($urandom_range(0, 14));
      end
      default: begin
        case ($urandom_range(0, 3))
          0:       b = 8'hE7;
          1:       b = 8'hC3;
          2:       b = 8'h81;
          default: b = 8'h00;
        endcase
      end
    endcase
    return b;
  endfunction

  function automatic lfps_pkg::in_item_t random_item();
    lfps_pkg::in_item_t x;
    int pick;
    x.cmd = ($urandom_range(0, 19) == 0) ? CMD_UNUSED : 2'($urandom_range(0, 2));
    pick = $urandom_range(0, 99);
    if (pick < 50) x.sensor_bits = dark_run();
    else if (pick < 62) x.sensor_bits = centered_bits(x.cmd);
    else if (pick < 70) x.sensor_bits = lfps_pkg::ALL_WHITE;
    else if (pick < 85) x.sensor_bits = 8'($urandom);
    else x.sensor_bits = dark_run() & dark_run();
    return x;
  endfunction

  task automatic send_item(input lfps_pkg::in_item_t item);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      @(negedge clk);
      sensor_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    sensor <= item;
    sensor_valid <= 1'b1;
    do @(posedge clk); while (sensor_stall !== 1'b0);
    sb.note_input(item);
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    @(negedge clk);
    sensor_valid <= 1'b0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [lfps_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [lfps_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic load_config(input logic [15:0] kp, ki, kil, kd, cs, ts, input bit spare);
    drain_results();
    write_reg(lfps_pkg::REG_PROP_GAIN, kp);
    write_reg(lfps_pkg::REG_INTEG_GAIN, ki);
    write_reg(lfps_pkg::REG_INTEG_GAIN_LEFT, kil);
    write_reg(lfps_pkg::REG_DERIV_GAIN, kd);
    write_reg(lfps_pkg::REG_CRUISE_SPEED, cs);
    write_reg(lfps_pkg::REG_TURN_SPEED, ts);
    if (spare) begin
      write_reg(REG_SPARE_LO, 16'($urandom));
      write_reg(REG_SPARE_HI, 16'($urandom));
    end
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic random_phase(input int count);
    int sent, k;
    lfps_pkg::in_item_t x;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 7) == 0) begin
        x.cmd = $urandom_range(0, 1) ? lfps_pkg::CMD_LEFT : lfps_pkg::CMD_RIGHT;
        k = $urandom_range(2, 4);
        sent += k;
        repeat (k) begin
          x.sensor_bits = dark_run();
          send_item(x);
        end
        k = $urandom_range(3, 4);
        sent += k;
        repeat (k) begin
          x.sensor_bits = centered_bits(x.cmd);
          send_item(x);
        end
      end else begin
        send_item(random_item());
        sent++;
      end
      if ($urandom_range(0, 39) == 0) drain_results();
    end
  endtask

  initial begin : drive_sink
    int n;
    wait (!rst);
    forever begin
      n = draw_gap();
      if (hold_req) begin
        n = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (n > 0) begin
        @(negedge clk);
        drive_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
        @(negedge clk);
        drive_stall <= 1'b0;
      end
      do @(posedge clk); while (drive_valid !== 1'b1);
      sb.check_result(drive);
    end
  end

  initial begin : stimulus
    logic [9:0] directed_items [24] = '{
      {8'hFF, lfps_pkg::CMD_STRAIGHT}, {8'h00, lfps_pkg::CMD_STRAIGHT},
      {8'hFE, lfps_pkg::CMD_STRAIGHT}, {8'h7F, lfps_pkg::CMD_STRAIGHT},
      {8'h0F, lfps_pkg::CMD_STRAIGHT}, {8'hF0, lfps_pkg::CMD_STRAIGHT},
      {8'hAA, lfps_pkg::CMD_STRAIGHT}, {8'h5A, lfps_pkg::CMD_STRAIGHT},
      {8'hE7, CMD_UNUSED},             {8'hC3, CMD_UNUSED},
      {8'hC0, lfps_pkg::CMD_LEFT},     {8'h00, lfps_pkg::CMD_LEFT},
      {8'h3F, lfps_pkg::CMD_LEFT},     {8'hFF, lfps_pkg::CMD_LEFT},
      {8'hE7, lfps_pkg::CMD_LEFT},     {8'hE7, lfps_pkg::CMD_LEFT},
      {8'hE7, lfps_pkg::CMD_LEFT},     {8'h0F, lfps_pkg::CMD_RIGHT},
      {8'h6F, lfps_pkg::CMD_RIGHT},    {8'hF0, lfps_pkg::CMD_RIGHT},
      {8'hF1, lfps_pkg::CMD_RIGHT},    {8'hF2, lfps_pkg::CMD_RIGHT},
      {8'hFF, lfps_pkg::CMD_RIGHT},    {8'h01, lfps_pkg::CMD_STRAIGHT}
    };
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_items[i]) send_item(lfps_pkg::in_item_t'(directed_items[i]));

    load_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), 1'b1);
    // fill the block while the drive side holds off
    idle_on = 1'b0;
    hold_req = 1'b1;
    repeat (12) send_item(random_item());
    idle_on = 1'b1;
    random_phase(60);

    load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 1'b0);
    random_phase(70);

    load_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    random_phase(70);

    load_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), 1'b1);
    idle_on = 1'b0;
    random_phase(40);
    idle_on = 1'b1;
    random_phase(60);

    // wind the integral up, then swing it the other way
    load_config(16'd3200, 16'd13, 16'd128, 16'd2176, 16'd320, 16'd320, 1'b0);
    idle_on = 1'b0;
    repeat (20) send_item(lfps_pkg::in_item_t'({8'h0F, lfps_pkg::CMD_STRAIGHT}));
    repeat (2) send_item(lfps_pkg::in_item_t'({8'hE7, lfps_pkg::CMD_STRAIGHT}));
    repeat (20) send_item(lfps_pkg::in_item_t'({8'hF0, lfps_pkg::CMD_STRAIGHT}));
    idle_on = 1'b1;
    random_phase(40);

    drain_results();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
